// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, types and segment lookup for the signed seven-segment
// scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int VALUE_W    = 18;
  localparam int PAT_W      = 7;
  localparam int POS_W      = 3;
  localparam int DIGIT_W    = 4;

  localparam int POW_N   = 10 ** NUM_DIGITS;
  localparam int CALC_W  = ($clog2(POW_N) > VALUE_W) ? $clog2(POW_N) : VALUE_W;
  localparam int PCNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CALC_W-1:0] MAG_LIMIT = CALC_W'(POW_N - 1);

  localparam logic [PAT_W-1:0] PAT_MINUS = 7'h40;
  localparam logic [PAT_W-1:0] PAT_BLANK = 7'h00;
  localparam logic [PAT_W-1:0] PAT_ZERO  = 7'h3F;

  // One queued word: sign and saturated magnitude.
  typedef struct packed {
    logic              neg;
    logic [CALC_W-1:0] mag;
  } item_t;

  // Weight of each digit position, indexed by position (entry 0 unused).
  typedef logic [CALC_W-1:0] scale_tab_t [NUM_DIGITS+1];

  function automatic scale_tab_t build_scale();
    scale_tab_t t;
    int         s;
    s    = 1;
    t[0] = '0;
    for (int p = NUM_DIGITS; p >= 1; p--) begin
      t[p] = CALC_W'(s);
      s    = s * 10;
    end
    return t;
  endfunction

  localparam scale_tab_t SCALE_AT = build_scale();

  function automatic logic [PAT_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = PAT_BLANK;
    endcase
    return p;
  endfunction

  // Mask a position count onto the strobe field width.
  function automatic logic [POS_W-1:0] to_pos(input logic [PCNT_W-1:0] c);
    logic [PCNT_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, c};
    return ext[POS_W-1:0];
  endfunction

endpackage

// ===== sv/signed_five_digit_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// signed_five_digit_seven_segment_scan
// Splits a signed value into decimal digit strobes with seven-segment
// patterns, leading blanks and a minus sign left of the first digit.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  value
//  out      out_valid/ out_stall segment_pattern, digit_position, last
//
//  A word yields five strobes, six when negative, one per cycle from the
//  scan sequencer while the output is not stalled.
//  A two-word queue sits between input and sequencer; input is taken while
//  the sequencer and output register are busy or stalled, until the queue is full.
//  rst is synchronous and empties the queue, sequencer and output register.
// ----------------------------------------------------------------------------
module signed_five_digit_seven_segment_scan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ssd_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ssd_pkg::PAT_W-1:0]          segment_pattern,
  output logic [ssd_pkg::POS_W-1:0]          digit_position,
  output logic                               last
);

  logic           q_valid;
  logic           q_pop;
  ssd_pkg::item_t q_item;

  ssd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ssd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .segment_pattern (segment_pattern),
    .digit_position  (digit_position),
    .last            (last)
  );

endmodule

// ===== sv/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front
// Accepts input words, takes the magnitude with saturation and queues
// sign plus magnitude for the scan sequencer.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [ssd_pkg::VALUE_W-1:0] value,
  output logic                          q_valid,
  output ssd_pkg::item_t                q_item,
  input  logic                          q_pop
);

  ssd_pkg::item_t                    ent [ssd_pkg::QDEPTH];
  logic [ssd_pkg::QPTR_W-1:0]        wr_ptr;
  logic [ssd_pkg::QPTR_W-1:0]        rd_ptr;
  logic [ssd_pkg::QCNT_W-1:0]        count;
  logic                              push;
  logic [ssd_pkg::VALUE_W-1:0]       raw_mag;
  ssd_pkg::item_t                    new_item;

  always_comb begin
    raw_mag      = value[ssd_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
    new_item.neg = value[ssd_pkg::VALUE_W-1];
    new_item.mag = ssd_pkg::CALC_W'(raw_mag);
    // clamp to all nines
    if (new_item.mag > ssd_pkg::MAG_LIMIT) begin
      new_item.mag = ssd_pkg::MAG_LIMIT;
    end
  end

  assign in_stall = (count == ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) q_pop |-> q_valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count overflow");

  property p_push_counts;
    @(posedge clk) disable iff (rst) (push && !q_pop) |=> (count == $past(count) + 1'b1);
  endproperty
  a_push_counts: assert property (p_push_counts) else $error("push not counted");

endmodule

// ===== sv/ssd_back.sv =====
// ----------------------------------------------------------------------------
// ssd_back
// Scan sequencer: emits one strobe per cycle while the output is not stalled,
// taking the queued word a decimal digit at a time, plus a minus strobe for negative words.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ssd_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssd_pkg::PAT_W-1:0]   segment_pattern,
  output logic [ssd_pkg::POS_W-1:0]   digit_position,
  output logic                        last
);

  logic                          busy;
  logic [ssd_pkg::CALC_W-1:0]    rem;
  logic                          neg;
  logic                          started;
  logic [ssd_pkg::PCNT_W-1:0]    pos;

  logic                          adv;
  logic [ssd_pkg::CALC_W-1:0]    scale;
  logic [ssd_pkg::CALC_W+3:0]    thr;
  logic [ssd_pkg::CALC_W+3:0]    take;
  logic [ssd_pkg::DIGIT_W-1:0]   digit;
  logic                          last_pos;
  logic                          emit_minus;
  logic                          finish;
  logic [ssd_pkg::PAT_W-1:0]     pat_next;
  logic [ssd_pkg::POS_W-1:0]     strobe_next;

  assign adv = !out_valid || !out_stall;

  // Pick the digit by comparing against each multiple of the weight.
  always_comb begin
    scale = ssd_pkg::SCALE_AT[pos];
    digit = '0;
    take  = '0;
    thr   = '0;
    for (int k = 1; k <= 9; k++) begin
      thr = (ssd_pkg::CALC_W + 4)'(scale) * (ssd_pkg::CALC_W + 4)'(k);
      if ({4'b0000, rem} >= thr) begin
        digit = ssd_pkg::DIGIT_W'(k);
        take  = thr;
      end
    end
  end

  always_comb begin
    last_pos   = (pos == ssd_pkg::PCNT_W'(ssd_pkg::NUM_DIGITS));
    emit_minus = neg && !started && (digit != '0);
    finish     = busy && adv && !emit_minus && last_pos;
    q_pop      = q_valid && (!busy || finish);
    if (emit_minus) begin
      pat_next    = ssd_pkg::PAT_MINUS;
      strobe_next = ssd_pkg::to_pos(pos - 1'b1);
    end else begin
      strobe_next = ssd_pkg::to_pos(pos);
      if (digit != '0) begin
        pat_next = ssd_pkg::seg_of(digit);
      end else if (started || last_pos) begin
        pat_next = ssd_pkg::PAT_ZERO;
      end else begin
        pat_next = ssd_pkg::PAT_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      segment_pattern <= pat_next;
      digit_position  <= strobe_next;
      last            <= !emit_minus && last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      started   <= 1'b0;
      pos       <= '0;
      rem       <= '0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      // load the next word, back to back with the final strobe
      if (q_pop) begin
        busy    <= 1'b1;
        rem     <= q_item.mag;
        neg     <= q_item.neg;
        started <= 1'b0;
        pos     <= ssd_pkg::PCNT_W'(1);
      end else if (busy && adv) begin
        if (emit_minus) begin
          neg <= 1'b0;
        end else begin
          rem <= rem - take[ssd_pkg::CALC_W-1:0];
          if (digit != '0) begin
            started <= 1'b1;
          end
          // hold the position on the final strobe
          if (last_pos) begin
            busy <= 1'b0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
      end
    end
  end

  property p_pos_range;
    @(posedge clk) disable iff (rst)
      busy |-> (pos >= ssd_pkg::PCNT_W'(1)) && (pos <= ssd_pkg::PCNT_W'(ssd_pkg::NUM_DIGITS));
  endproperty
  a_pos_range: assert property (p_pos_range) else $error("scan position out of range");

  property p_last_shows;
    @(posedge clk) disable iff (rst)
      (out_valid && last) |-> (segment_pattern != ssd_pkg::PAT_BLANK);
  endproperty
  a_last_shows: assert property (p_last_shows) else $error("rightmost digit blank");

  property p_minus_not_last;
    @(posedge clk) disable iff (rst)
      (out_valid && (segment_pattern == ssd_pkg::PAT_MINUS)) |-> !last;
  endproperty
  a_minus_not_last: assert property (p_minus_not_last) else $error("minus on final strobe");

  property p_rem_fits;
    @(posedge clk) disable iff (rst)
      (busy && !emit_minus) |-> ({4'b0000, rem} <
        ((ssd_pkg::CALC_W + 4)'(scale) * (ssd_pkg::CALC_W + 4)'(10)));
  endproperty
  a_rem_fits: assert property (p_rem_fits) else $error("remainder exceeds digit weight");

endmodule
